// ----- rtl/reelh_pkg.sv -----
// Shared types, constants and the error-probability table of the expected-error histogram.
package reelh_pkg;

    // Field and register widths fixed by the interface.
    localparam int EE_W       = 36;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 13;
    localparam int LSUM_W     = 48;
    localparam int STEP_W     = 13;
    localparam int OFS_W      = 7;
    localparam int NCUT_CFG_W = 3;
    localparam int ROM_W      = 25;
    localparam int QUAL_W     = 8;
    localparam int QSCORE_W   = 6;
    localparam int QBIN_W     = 6;
    localparam int QCUT_W     = 2;
    localparam int OUT_BIN_W  = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 36;

    localparam int CUTOFF_REGS     = 4;
    localparam int MAX_READ_LEN    = 4096;
    localparam int DEF_NUM_BINS    = 64;
    localparam int DEF_NUM_CUTOFFS = 4;

    localparam logic [STEP_W-1:0]   STEP_MAX  = '1;
    localparam logic [QSCORE_W-1:0] QSCORE_MAX = '1;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_LEN_LO       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_STEP     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_COUNT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EE_CUTOFF_0  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EE_CUTOFF_1  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EE_CUTOFF_2  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EE_CUTOFF_3  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUAL_OFFSET  = 4'd7;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]      RST_LEN_LO       = 13'd50;
    localparam logic [LEN_W-1:0]      RST_LEN_STEP     = 13'd50;
    localparam logic [NCUT_CFG_W-1:0] RST_CUTOFF_COUNT = 3'd3;
    localparam logic [EE_W-1:0]       RST_EE_CUTOFF_0  = 36'd8388608;
    localparam logic [EE_W-1:0]       RST_EE_CUTOFF_1  = 36'd16777216;
    localparam logic [EE_W-1:0]       RST_EE_CUTOFF_2  = 36'd33554432;
    localparam logic [EE_W-1:0]       RST_EE_CUTOFF_3  = '1;
    localparam logic [OFS_W-1:0]      RST_QUAL_OFFSET  = 7'd33;

    // Input beat kinds.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_TOTALS = 2'd2;

    // Operation carried down the pipeline.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLOSE,
        OP_COUNT,
        OP_TOTALS
    } op_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [QUAL_W-1:0] qual_char;
        logic              last;
        logic [QCUT_W-1:0] query_cutoff;
        logic [QBIN_W-1:0] query_bin;
    } in_beat_t;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [CNT_W-1:0]     read_total;
        logic [LEN_W-1:0]     max_length;
        logic [LSUM_W-1:0]    length_sum;
        logic [OUT_BIN_W-1:0] highest_bin;
        logic                 bin_overflow;
    } out_beat_t;

    // round(2^24 * 10^(-q/10)) for Phred scores 0 to 63.
    localparam logic [ROM_W-1:0] ERR_ROM [64] = '{
        25'd16777216, 25'd13326616, 25'd10585708, 25'd8408526, 25'd6679130,
        25'd5305422,  25'd4214246,  25'd3347495,  25'd2659010, 25'd2112126,
        25'd1677722,  25'd1332662,  25'd1058571,  25'd840853,  25'd667913,
        25'd530542,   25'd421425,   25'd334749,   25'd265901,  25'd211213,
        25'd167772,   25'd133266,   25'd105857,   25'd84085,   25'd66791,
        25'd53054,    25'd42142,    25'd33475,    25'd26590,   25'd21121,
        25'd16777,    25'd13327,    25'd10586,    25'd8409,    25'd6679,
        25'd5305,     25'd4214,     25'd3347,     25'd2659,    25'd2112,
        25'd1678,     25'd1333,     25'd1059,     25'd841,     25'd668,
        25'd531,      25'd421,      25'd335,      25'd266,     25'd211,
        25'd168,      25'd133,      25'd106,      25'd84,      25'd67,
        25'd53,       25'd42,       25'd33,       25'd27,      25'd21,
        25'd17,       25'd13,       25'd11,       25'd8
    };

endpackage

// ----- rtl/read_expected_error_length_histogram.sv -----
// Expected-error by read-length histogram: counter memory, read scalars and query results.
// Throughput: one beat per cycle, characters and queries alike, while s_ready is high (it
// drops during clearing and when the result queue lacks room); the count memory is read in
// stage 1 and written back in stage 2, with forwarding for back-to-back updates of a row.
// A query's result passes stages 1 and 2 into the result queue, which drives m_valid.
// Reset sets the control and config registers, then zeroes the count memory, s_ready low.
module read_expected_error_length_histogram #(
    parameter int NUM_BINS    = reelh_pkg::DEF_NUM_BINS,
    parameter int NUM_CUTOFFS = reelh_pkg::DEF_NUM_CUTOFFS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  reelh_pkg::in_beat_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output reelh_pkg::out_beat_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [reelh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [reelh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import reelh_pkg::*;

    // Memory address covers the bins; the bin counter must also hold NUM_BINS itself,
    // which marks a read that has run past the last bin.
    localparam int ADDR_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BIDX_W     = $clog2(NUM_BINS + 1);
    localparam int LANE_W     = (NUM_CUTOFFS > 1) ? $clog2(NUM_CUTOFFS) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = 2;
    localparam int FCNT_W     = 3;
    localparam int OCC_W      = 4;

    // One memory row holds the counters of all cutoffs for one length bin.
    typedef logic [NUM_CUTOFFS-1:0][CNT_W-1:0] row_t;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]      len_lo_reg;
    logic [LEN_W-1:0]      len_step_reg;
    logic [NCUT_CFG_W-1:0] cutoff_count_reg;
    logic [EE_W-1:0]       ee_cutoff_reg [CUTOFF_REGS];
    logic [OFS_W-1:0]      qual_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_lo_reg       <= RST_LEN_LO;
            len_step_reg     <= RST_LEN_STEP;
            cutoff_count_reg <= RST_CUTOFF_COUNT;
            ee_cutoff_reg[0] <= RST_EE_CUTOFF_0;
            ee_cutoff_reg[1] <= RST_EE_CUTOFF_1;
            ee_cutoff_reg[2] <= RST_EE_CUTOFF_2;
            ee_cutoff_reg[3] <= RST_EE_CUTOFF_3;
            qual_offset_reg  <= RST_QUAL_OFFSET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LEN_LO:       len_lo_reg       <= cfg_data[LEN_W-1:0];
                REG_LEN_STEP:     len_step_reg     <= cfg_data[LEN_W-1:0];
                REG_CUTOFF_COUNT: cutoff_count_reg <= cfg_data[NCUT_CFG_W-1:0];
                REG_EE_CUTOFF_0:  ee_cutoff_reg[0] <= cfg_data[EE_W-1:0];
                REG_EE_CUTOFF_1:  ee_cutoff_reg[1] <= cfg_data[EE_W-1:0];
                REG_EE_CUTOFF_2:  ee_cutoff_reg[2] <= cfg_data[EE_W-1:0];
                REG_EE_CUTOFF_3:  ee_cutoff_reg[3] <= cfg_data[EE_W-1:0];
                REG_QUAL_OFFSET:  qual_offset_reg  <= cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Declarations of the pipeline and statistics state.
    // ------------------------------------------------------------------
    logic [EE_W-1:0]   ee_sum_reg,        ee_sum_next;
    logic [LEN_W-1:0]  read_pos_reg,      read_pos_next;
    logic [STEP_W-1:0] step_cnt_reg,      step_cnt_next;
    logic [BIDX_W-1:0] bin_idx_reg,       bin_idx_next;
    logic [CNT_W-1:0]  reads_seen_reg,    reads_seen_next;
    logic [LEN_W-1:0]  longest_reg,       longest_next;
    logic [LSUM_W-1:0] total_len_reg,     total_len_next;
    logic              overflow_reg,      overflow_next;
    logic [ADDR_W-1:0] top_bin_reg,       top_bin_next;

    // Stage 1: after the input beat is taken; the memory read is issued here.
    op_t               s1_op_reg,   s1_op_next;
    logic [ADDR_W-1:0] s1_addr_reg, s1_addr_next;
    logic [EE_W-1:0]   s1_ee_reg,   s1_ee_next;
    logic [LANE_W-1:0] s1_lane_reg, s1_lane_next;
    logic              s1_qok_reg,  s1_qok_next;

    // Stage 2: the row is back from memory; counters are updated or a result is made.
    op_t                  s2_op_reg,      s2_op_next;
    logic [ADDR_W-1:0]    s2_addr_reg;
    logic [NUM_CUTOFFS-1:0] s2_mask_reg,  s2_mask_next;
    logic [LANE_W-1:0]    s2_lane_reg;
    logic                 s2_qok_reg;
    logic                 s2_fwd_reg,     s2_fwd_next;
    row_t                 s2_fwd_row_reg;
    logic [CNT_W-1:0]     s2_reads_reg;
    logic [LEN_W-1:0]     s2_longest_reg;
    logic [LSUM_W-1:0]    s2_total_reg;
    logic [ADDR_W-1:0]    s2_top_reg;
    logic                 s2_ovf_reg;

    // Count memory and its clearing pass.
    row_t              count_mem [NUM_BINS];
    row_t              mem_rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    row_t              mem_wdata;
    logic              clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg,   clr_addr_next;

    // Result queue.
    out_beat_t         fifo_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] fifo_wr_reg, fifo_wr_next;
    logic [FPTR_W-1:0] fifo_rd_reg, fifo_rd_next;
    logic [FCNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic              fifo_push, fifo_pop;
    out_beat_t         push_beat;

    // ------------------------------------------------------------------
    // Input acceptance. A beat is taken only when the result queue has room for
    // every query already in flight plus this one, so the pipeline never stalls.
    // ------------------------------------------------------------------
    logic [OCC_W-1:0] occupancy;
    logic             in_take;

    assign occupancy = OCC_W'(fifo_cnt_reg)
                     + OCC_W'(s1_op_reg == OP_COUNT || s1_op_reg == OP_TOTALS)
                     + OCC_W'(s2_op_reg == OP_COUNT || s2_op_reg == OP_TOTALS);
    assign s_ready   = !clr_active_reg && (occupancy < OCC_W'(FIFO_DEPTH));
    assign in_take   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: Phred score, table lookup, running sum and bin closure.
    // ------------------------------------------------------------------
    logic [QUAL_W-1:0]   q_diff;
    logic [QSCORE_W-1:0] q_score;
    logic [ROM_W-1:0]    err_val;
    logic [EE_W:0]       ee_add;
    logic [EE_W-1:0]     ee_new;
    logic [LEN_W-1:0]    pos_new;
    logic [STEP_W-1:0]   step_new;
    logic [LEN_W-1:0]    target;
    logic                bin_close;
    logic                bin_full;
    logic [LSUM_W:0]     lsum_add;

    always_comb begin
        // A character below the offset scores zero; scores above 63 clamp to 63.
        q_diff = s_data.qual_char - QUAL_W'(qual_offset_reg);
        if (s_data.qual_char < QUAL_W'(qual_offset_reg)) begin
            q_score = '0;
        end else if (q_diff > QUAL_W'(QSCORE_MAX)) begin
            q_score = QSCORE_MAX;
        end else begin
            q_score = q_diff[QSCORE_W-1:0];
        end
        err_val = ERR_ROM[q_score];

        ee_add = {1'b0, ee_sum_reg} + (EE_W + 1)'(err_val);
        ee_new = ee_add[EE_W] ? '1 : ee_add[EE_W-1:0];

        pos_new  = (read_pos_reg < LEN_W'(MAX_READ_LEN)) ? read_pos_reg + 1'b1 : read_pos_reg;
        step_new = (step_cnt_reg == STEP_MAX) ? step_cnt_reg : step_cnt_reg + 1'b1;

        // The first bin closes at len_lo, each later one after len_step more.
        target = (bin_idx_reg == '0) ? len_lo_reg : len_step_reg;
        if (target == '0) begin
            target = LEN_W'(1);
        end
        bin_close = (step_new == STEP_W'(target));
        bin_full  = (bin_idx_reg == BIDX_W'(NUM_BINS));

        lsum_add = {1'b0, total_len_reg} + (LSUM_W + 1)'(pos_new);
    end

    always_comb begin
        ee_sum_next     = ee_sum_reg;
        read_pos_next   = read_pos_reg;
        step_cnt_next   = step_cnt_reg;
        bin_idx_next    = bin_idx_reg;
        reads_seen_next = reads_seen_reg;
        longest_next    = longest_reg;
        total_len_next  = total_len_reg;
        overflow_next   = overflow_reg;
        if (in_take && s_data.kind == KIND_CHAR) begin
            ee_sum_next   = ee_new;
            read_pos_next = pos_new;
            step_cnt_next = step_new;
            if (bin_close) begin
                step_cnt_next = '0;
                if (bin_full) begin
                    overflow_next = 1'b1;
                end else begin
                    bin_idx_next = bin_idx_reg + 1'b1;
                end
            end
            if (s_data.last) begin
                if (reads_seen_reg != '1) begin
                    reads_seen_next = reads_seen_reg + 1'b1;
                end
                if (pos_new > longest_reg) begin
                    longest_next = pos_new;
                end
                total_len_next = lsum_add[LSUM_W] ? '1 : lsum_add[LSUM_W-1:0];
                ee_sum_next    = '0;
                read_pos_next  = '0;
                step_cnt_next  = '0;
                bin_idx_next   = '0;
            end
        end
    end

    // What the accepted beat hands to stage 1.
    always_comb begin
        s1_op_next   = OP_NONE;
        s1_addr_next = ADDR_W'(s_data.query_bin);
        s1_ee_next   = ee_new;
        s1_lane_next = LANE_W'(s_data.query_cutoff);
        s1_qok_next  = (32'(s_data.query_bin) < NUM_BINS)
                    && (32'(s_data.query_cutoff) < NUM_CUTOFFS);
        if (in_take) begin
            unique case (s_data.kind)
                KIND_CHAR: begin
                    s1_addr_next = ADDR_W'(bin_idx_reg);
                    if (bin_close && !bin_full) begin
                        s1_op_next = OP_CLOSE;
                    end
                end
                KIND_COUNT:  s1_op_next = OP_COUNT;
                KIND_TOTALS: s1_op_next = OP_TOTALS;
                default:     s1_op_next = OP_NONE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: cutoff comparisons, highest bin, memory read and forwarding check.
    // ------------------------------------------------------------------
    row_t cur_row;
    row_t upd_row;

    always_comb begin
        s2_op_next   = s1_op_reg;
        top_bin_next = top_bin_reg;
        for (int k = 0; k < NUM_CUTOFFS; k++) begin
            s2_mask_next[k] = (32'(cutoff_count_reg) > k) && (s1_ee_reg <= ee_cutoff_reg[k]);
        end
        if (s1_op_reg == OP_CLOSE && (|s2_mask_next) && (s1_addr_reg > top_bin_reg)) begin
            top_bin_next = s1_addr_reg;
        end
        // The row written back this cycle is not yet in the memory's read data.
        s2_fwd_next = (s2_op_reg == OP_CLOSE) && (s2_addr_reg == s1_addr_reg);
    end

    // ------------------------------------------------------------------
    // Stage 2: saturating counter update and result assembly.
    // ------------------------------------------------------------------
    always_comb begin
        cur_row = s2_fwd_reg ? s2_fwd_row_reg : mem_rd_reg;
        upd_row = cur_row;
        for (int k = 0; k < NUM_CUTOFFS; k++) begin
            if (s2_mask_reg[k] && cur_row[k] != '1) begin
                upd_row[k] = cur_row[k] + 1'b1;
            end
        end
    end

    always_comb begin
        push_beat = '0;
        fifo_push = 1'b0;
        unique case (s2_op_reg)
            OP_COUNT: begin
                fifo_push       = 1'b1;
                push_beat.count = s2_qok_reg ? cur_row[s2_lane_reg] : '0;
            end
            OP_TOTALS: begin
                fifo_push              = 1'b1;
                push_beat.read_total   = s2_reads_reg;
                push_beat.max_length   = s2_longest_reg;
                push_beat.length_sum   = s2_total_reg;
                push_beat.highest_bin  = OUT_BIN_W'(s2_top_reg);
                push_beat.bin_overflow = s2_ovf_reg;
            end
            OP_NONE, OP_CLOSE: ;
            default: ;
        endcase
    end

    // Write port: the clearing pass owns it after reset, the bin updates afterwards.
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NUM_BINS - 1)) begin
                clr_active_next = 1'b0;
            end
        end else begin
            mem_we    = (s2_op_reg == OP_CLOSE);
            mem_waddr = s2_addr_reg;
            mem_wdata = upd_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= count_mem[s1_addr_reg];
    end

    // ------------------------------------------------------------------
    // Result queue towards the m_ side.
    // ------------------------------------------------------------------
    assign m_valid  = (fifo_cnt_reg != '0);
    assign m_data   = fifo_reg[fifo_rd_reg];
    assign fifo_pop = m_valid && m_ready;

    always_comb begin
        fifo_wr_next  = fifo_push ? fifo_wr_reg + 1'b1 : fifo_wr_reg;
        fifo_rd_next  = fifo_pop ? fifo_rd_reg + 1'b1 : fifo_rd_reg;
        fifo_cnt_next = fifo_cnt_reg + FCNT_W'(fifo_push) - FCNT_W'(fifo_pop);
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_reg[fifo_wr_reg] <= push_beat;
        end
    end

    // ------------------------------------------------------------------
    // Control and statistics registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ee_sum_reg     <= '0;
            read_pos_reg   <= '0;
            step_cnt_reg   <= '0;
            bin_idx_reg    <= '0;
            reads_seen_reg <= '0;
            longest_reg    <= '0;
            total_len_reg  <= '0;
            overflow_reg   <= 1'b0;
            top_bin_reg    <= '0;
            s1_op_reg      <= OP_NONE;
            s2_op_reg      <= OP_NONE;
            s2_fwd_reg     <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fifo_wr_reg    <= '0;
            fifo_rd_reg    <= '0;
            fifo_cnt_reg   <= '0;
        end else begin
            ee_sum_reg     <= ee_sum_next;
            read_pos_reg   <= read_pos_next;
            step_cnt_reg   <= step_cnt_next;
            bin_idx_reg    <= bin_idx_next;
            reads_seen_reg <= reads_seen_next;
            longest_reg    <= longest_next;
            total_len_reg  <= total_len_next;
            overflow_reg   <= overflow_next;
            top_bin_reg    <= top_bin_next;
            s1_op_reg      <= s1_op_next;
            s2_op_reg      <= s2_op_next;
            s2_fwd_reg     <= s2_fwd_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            fifo_wr_reg    <= fifo_wr_next;
            fifo_rd_reg    <= fifo_rd_next;
            fifo_cnt_reg   <= fifo_cnt_next;
        end
    end

    // Pipeline payload. The totals are sampled while a query sits in stage 1, when
    // every earlier beat has left its mark and no later one has yet.
    always_ff @(posedge aclk) begin
        s1_addr_reg    <= s1_addr_next;
        s1_ee_reg      <= s1_ee_next;
        s1_lane_reg    <= s1_lane_next;
        s1_qok_reg     <= s1_qok_next;
        s2_addr_reg    <= s1_addr_reg;
        s2_mask_reg    <= s2_mask_next;
        s2_lane_reg    <= s1_lane_reg;
        s2_qok_reg     <= s1_qok_reg;
        s2_fwd_row_reg <= upd_row;
        s2_reads_reg   <= reads_seen_reg;
        s2_longest_reg <= longest_reg;
        s2_total_reg   <= total_len_reg;
        s2_top_reg     <= top_bin_next;
        s2_ovf_reg     <= overflow_reg;
    end

endmodule
